@@ rtl/core/dual_wheel_velocity_conditioner_top_assert.svh @@
// ----------------------------------------------------------------------------
// dual wheel velocity conditioner assertion macros
// shared property wrappers for the checker of the conditioner
// ----------------------------------------------------------------------------
`ifndef DUAL_WHEEL_VELOCITY_CONDITIONER_TOP_ASSERT_SVH
`define DUAL_WHEEL_VELOCITY_CONDITIONER_TOP_ASSERT_SVH

// clocked property, switched off while reset is asserted
`define DWVC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property that also has to hold across reset
`define DWVC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/dwvc_pkg.sv @@
// ----------------------------------------------------------------------------
// dwvc_pkg
// constants shared by the dual wheel velocity conditioner and its interfaces
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dwvc_pkg;

    // default velocity width, signed Q8.8
    localparam int VEL_WIDTH_DEF = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP  = 3'd4;

    // register widths
    localparam int LIM_W  = 15;
    localparam int GAIN_W = 16;
    localparam int OFS_W  = 16;

    // gain is unsigned Q4.12
    localparam int GAIN_FRAC = 12;

    // reset values
    localparam logic [LIM_W-1:0]         DEAD_ZONE_RST = 15'd0;
    localparam logic [GAIN_W-1:0]        GAIN_RST      = 16'd4096;
    localparam logic signed [OFS_W-1:0]  OFFSET_RST    = 16'sd0;
    localparam logic [LIM_W-1:0]         MAX_SPEED_RST = 15'd32767;
    localparam logic [LIM_W-1:0]         MAX_STEP_RST  = 15'd32767;

endpackage

@@ rtl/core/dwvc_if.sv @@
// ----------------------------------------------------------------------------
// dwvc interfaces
// valid/ready channels for commands, drive results and register writes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// command pair channel
interface dwvc_cmd_if import dwvc_pkg::*; #(
    parameter int VEL_WIDTH = VEL_WIDTH_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [VEL_WIDTH-1:0] left_cmd;
    logic signed [VEL_WIDTH-1:0] right_cmd;

    modport source (output valid, output left_cmd, output right_cmd, input ready);
    modport sink   (input valid, input left_cmd, input right_cmd, output ready);
endinterface

// conditioned drive pair channel
interface dwvc_drive_if import dwvc_pkg::*; #(
    parameter int VEL_WIDTH = VEL_WIDTH_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [VEL_WIDTH-1:0] left_drive;
    logic signed [VEL_WIDTH-1:0] right_drive;

    modport source (output valid, output left_drive, output right_drive, input ready);
    modport sink   (input valid, input left_drive, input right_drive, output ready);
endinterface

// register write channel
interface dwvc_cfg_if import dwvc_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/dual_wheel_velocity_conditioner_top.sv @@
// One command pair (left, right) is taken per clock while the output side is
// not stalled, and one drive pair comes out per pair via the command register
// and then the drive register. Each wheel goes through dead zone, gain and
// offset, clamp at max_speed, sign restore, slew limit against its last
// output and saturation to VEL_WIDTH bits, all combinational between the
// command register and the drive register; that path (one multiply then a
// few compares per wheel) sets the clock. Sustained rate is one pair per
// cycle unless stalled; a new command is taken while a finished result waits.
// Registers are written through the config channel, which is always ready;
// unknown indexes are ignored. Registers should only be written while idle.
// ----------------------------------------------------------------------------
// dual_wheel_velocity_conditioner_top
// per-wheel dead zone, affine scaling, clamp and slew rate limiter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_wheel_velocity_conditioner_top import dwvc_pkg::*; #(
    parameter int VEL_WIDTH = VEL_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dwvc_cfg_if.sink      i_cfg,
    dwvc_cmd_if.sink      i_cmd,
    dwvc_drive_if.source  o_drive
);

    // working width, wide enough for scaled magnitude plus slew step
    localparam int DW = VEL_WIDTH + 22;
    localparam int PW = VEL_WIDTH + GAIN_W;
    localparam int CW = VEL_WIDTH + LIM_W;

    // configuration registers
    logic [LIM_W-1:0]        r_dead_zone;
    logic [GAIN_W-1:0]       r_gain;
    logic signed [OFS_W-1:0] r_offset;
    logic [LIM_W-1:0]        r_max_speed;
    logic [LIM_W-1:0]        r_max_step;

    // lane 0 is left, lane 1 is right
    logic signed [VEL_WIDTH-1:0] r_cmd  [2];
    logic signed [VEL_WIDTH-1:0] r_prev [2];
    logic signed [VEL_WIDTH-1:0] n_prev [2];
    logic                        r_in_valid;
    logic                        n_in_valid;
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic                        cmd_accept;
    logic                        advance;

    // one wheel: dead zone, scale, clamp, sign, slew, saturate
    function automatic logic signed [VEL_WIDTH-1:0] condition(
        input logic signed [VEL_WIDTH-1:0] cmd,
        input logic signed [VEL_WIDTH-1:0] prev
    );
        logic                 neg;
        logic [VEL_WIDTH-1:0] cmd_u;
        logic [VEL_WIDTH-1:0] mag;
        logic [PW-1:0]        prod;
        logic signed [DW-1:0] val;
        logic signed [DW-1:0] lim;
        logic signed [DW-1:0] prev_x;
        logic signed [DW-1:0] step;
        logic signed [DW-1:0] diff;
        logic signed [DW-1:0] sat_hi;
        logic signed [DW-1:0] sat_lo;
        neg   = cmd[VEL_WIDTH-1];
        cmd_u = cmd;
        // most negative command maps to its exact magnitude as unsigned
        mag   = neg ? (~cmd_u + VEL_WIDTH'(1)) : cmd_u;
        prod  = PW'(mag) * PW'(r_gain);
        if (CW'(mag) < CW'(r_dead_zone)) begin
            val = '0;
        end else begin
            val = DW'($signed({1'b0, prod[PW-1:GAIN_FRAC]})) + DW'(r_offset);
        end
        // upper clamp only, a negative scaled magnitude stays as it is
        lim = DW'($signed({1'b0, r_max_speed}));
        if (val > lim) begin
            val = lim;
        end
        if (neg) begin
            val = -val;
        end
        // slew limit against the last output of this wheel
        prev_x = DW'(prev);
        step   = DW'($signed({1'b0, r_max_step}));
        diff   = val - prev_x;
        if (diff > step) begin
            val = prev_x + step;
        end else if (diff < -step) begin
            val = prev_x - step;
        end
        // saturate to the velocity range
        sat_hi = DW'($signed({1'b0, {(VEL_WIDTH-1){1'b1}}}));
        sat_lo = -sat_hi - DW'(1);
        if (val > sat_hi) begin
            val = sat_hi;
        end else if (val < sat_lo) begin
            val = sat_lo;
        end
        return VEL_WIDTH'(val);
    endfunction

    // register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone <= DEAD_ZONE_RST;
            r_gain      <= GAIN_RST;
            r_offset    <= OFFSET_RST;
            r_max_speed <= MAX_SPEED_RST;
            r_max_step  <= MAX_STEP_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_DEAD_ZONE: r_dead_zone <= i_cfg.data[LIM_W-1:0];
                REG_GAIN:      r_gain      <= i_cfg.data[GAIN_W-1:0];
                REG_OFFSET:    r_offset    <= $signed(i_cfg.data[OFS_W-1:0]);
                REG_MAX_SPEED: r_max_speed <= i_cfg.data[LIM_W-1:0];
                REG_MAX_STEP:  r_max_step  <= i_cfg.data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: input stage drains whenever the output slot frees up
    assign advance     = r_in_valid && (!r_out_valid || o_drive.ready);
    assign i_cmd.ready = !r_in_valid || advance;
    assign cmd_accept  = i_cmd.valid && i_cmd.ready;

    always_comb begin
        n_in_valid  = cmd_accept ? 1'b1 : (advance ? 1'b0 : r_in_valid);
        n_out_valid = advance ? 1'b1 : (o_drive.ready ? 1'b0 : r_out_valid);
    end

    // per-wheel datapath
    always_comb begin
        n_prev[0] = condition(r_cmd[0], r_prev[0]);
        n_prev[1] = condition(r_cmd[1], r_prev[1]);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // command register
    always_ff @(posedge i_clk) begin
        if (cmd_accept) begin
            r_cmd[0] <= i_cmd.left_cmd;
            r_cmd[1] <= i_cmd.right_cmd;
        end
    end

    // drive register, which is also the previous output of each wheel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev[0] <= '0;
            r_prev[1] <= '0;
        end else if (advance) begin
            r_prev[0] <= n_prev[0];
            r_prev[1] <= n_prev[1];
        end
    end

    assign o_drive.valid       = r_out_valid;
    assign o_drive.left_drive  = r_prev[0];
    assign o_drive.right_drive = r_prev[1];

endmodule

@@ rtl/core/dwvc_checker.sv @@
// ----------------------------------------------------------------------------
// dwvc_checker
// port level checks of the conditioner, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "dual_wheel_velocity_conditioner_top_assert.svh"

module dwvc_checker import dwvc_pkg::*; #(
    parameter int VEL_WIDTH = VEL_WIDTH_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_cmd_valid,
    input logic                        i_cmd_ready,
    input logic                        i_drive_valid,
    input logic                        i_drive_ready,
    input logic signed [VEL_WIDTH-1:0] i_left_drive,
    input logic signed [VEL_WIDTH-1:0] i_right_drive
);

    logic cmd_accept;
    logic drive_stall;

    assign cmd_accept  = i_cmd_valid && i_cmd_ready;
    assign drive_stall = i_drive_valid && !i_drive_ready;

    // a stalled drive transaction keeps its payload
    `DWVC_ASSERT(a_drive_hold, i_clk, i_rst_n, drive_stall |=> i_drive_valid && $stable(i_left_drive) && $stable(i_right_drive), "drive payload changed while stalled")

    // reset empties the output
    `DWVC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_drive_valid, "drive valid after reset")

    // an empty output fills only after a command transaction has passed the command register
    `DWVC_ASSERT(a_rise_latency, i_clk, i_rst_n, $rose(i_drive_valid) |-> $past(cmd_accept, 2), "drive appeared without a command")

endmodule

bind dual_wheel_velocity_conditioner_top dwvc_checker #(
    .VEL_WIDTH (VEL_WIDTH)
) u_dwvc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cmd_valid   (i_cmd.valid),
    .i_cmd_ready   (i_cmd.ready),
    .i_drive_valid (o_drive.valid),
    .i_drive_ready (o_drive.ready),
    .i_left_drive  (o_drive.left_drive),
    .i_right_drive (o_drive.right_drive)
);

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// checks the dual wheel velocity conditioner against a cycle-free predictor:
// a directed table of corner commands and register settings, then random
// command pairs over random register settings, with bursty command traffic,
// a stalling drive receiver and one long receiver hold-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import dwvc_pkg::*;

    localparam int VW          = VEL_WIDTH_DEF;
    localparam int RAND_ITEMS  = 900;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AT     = 120;
    localparam int HOLD_CYCLES = 300;

    // indexes past the last register, writes there are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_MAX_STEP + CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

    typedef logic signed [VW-1:0] t_vel;

    typedef struct {
        t_vel left;
        t_vel right;
    } t_drive_pair;

    typedef enum logic {ROW_CMD, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        t_vel                  left;
        t_vel                  right;
        bit                    typed;
        t_vel                  want_left;
        t_vel                  want_right;
    } t_dir_row;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_ALTERNATE} t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    dwvc_cfg_if                    cfg_bus ();
    dwvc_cmd_if   #(.VEL_WIDTH(VW)) cmd_bus ();
    dwvc_drive_if #(.VEL_WIDTH(VW)) drive_bus ();

    dual_wheel_velocity_conditioner_top #(.VEL_WIDTH(VW)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_cmd   (cmd_bus),
        .o_drive (drive_bus)
    );

    // predictor copy of the registers and the last drive per wheel
    logic [LIM_W-1:0]        dz_r;
    logic [GAIN_W-1:0]       gain_r;
    logic signed [OFS_W-1:0] ofs_r;
    logic [LIM_W-1:0]        speed_r;
    logic [LIM_W-1:0]        step_r;
    t_vel                    last_left;
    t_vel                    last_right;

    t_drive_pair expected_drives[$];
    int          fails       = 0;
    int          drives_seen = 0;
    int          cmds_taken  = 0;
    int          burst_left  = 0;
    longint      cycles      = 0;

    // clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // one wheel: dead zone, scale and offset, clamp, sign, slew, saturate
    function automatic t_vel condition_wheel(input t_vel cmd, input t_vel last);
        longint mag;
        longint val;
        longint stp;
        longint hi;
        longint lo;
        mag = (cmd < 0) ? -longint'(cmd) : longint'(cmd);
        if (mag < longint'(dz_r)) begin
            val = 0;
        end else begin
            val = ((mag * longint'(gain_r)) >>> GAIN_FRAC) + longint'(ofs_r);
        end
        if (val > longint'(speed_r)) val = longint'(speed_r);
        if (cmd < 0) val = -val;
        stp = longint'(step_r);
        if (val - longint'(last) > stp) begin
            val = longint'(last) + stp;
        end else if (val - longint'(last) < -stp) begin
            val = longint'(last) - stp;
        end
        hi = (64'sd1 <<< (VW - 1)) - 1;
        lo = -hi - 1;
        if (val > hi) val = hi;
        if (val < lo) val = lo;
        return val[VW-1:0];
    endfunction

    function automatic t_dir_row cmd_row(input t_vel l, input t_vel r);
        t_dir_row row;
        row = '{kind: ROW_CMD, idx: '0, data: '0, left: l, right: r,
                typed: 1'b0, want_left: '0, want_right: '0};
        return row;
    endfunction

    function automatic t_dir_row chk_row(input t_vel l, input t_vel r,
                                         input t_vel el, input t_vel er);
        t_dir_row row;
        row = cmd_row(l, r);
        row.typed      = 1'b1;
        row.want_left  = el;
        row.want_right = er;
        return row;
    endfunction

    function automatic t_dir_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        t_dir_row row;
        row = cmd_row('0, '0);
        row.kind = ROW_CFG;
        row.idx  = idx;
        row.data = data;
        return row;
    endfunction

    // random register values, extremes and stray upper bits included
    function automatic logic [CFG_DATA_W-1:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return CFG_DATA_W'($urandom_range(0, 1023));
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return GAIN_RST;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_offset();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return '0;
            3:       return CFG_DATA_W'(int'($urandom_range(0, 1023)) - 512);
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    // commands: extremes, around the dead zone edge, small, full range
    function automatic t_vel pick_cmd();
        t_vel v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       v = 16'sh8000;
                    1:       v = 16'sh7FFF;
                    2:       v = '0;
                    3:       v = 16'sd1;
                    default: v = -16'sd1;
                endcase
            end
            1, 2: begin
                v = VW'(int'(dz_r) + int'($urandom_range(0, 4)) - 2);
                if ($urandom_range(0, 1)) v = -v;
            end
            3, 4: begin
                v = VW'($urandom_range(0, 2047));
                if ($urandom_range(0, 1)) v = -v;
            end
            default: v = VW'($urandom);
        endcase
        return v;
    endfunction

    // register write transaction, predictor follows on acceptance
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = data;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        case (idx)
            REG_DEAD_ZONE: dz_r    = data[LIM_W-1:0];
            REG_GAIN:      gain_r  = data[GAIN_W-1:0];
            REG_OFFSET:    ofs_r   = data[OFS_W-1:0];
            REG_MAX_SPEED: speed_r = data[LIM_W-1:0];
            REG_MAX_STEP:  step_r  = data[LIM_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    // command transaction in bursts with random gaps between them
    task automatic send_pair(input t_vel l, input t_vel r, input bit typed,
                             input t_vel el, input t_vel er);
        t_drive_pair want;
        int          gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge i_clk);
                cmd_bus.valid = 1'b0;
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge i_clk);
        cmd_bus.valid     = 1'b1;
        cmd_bus.left_cmd  = l;
        cmd_bus.right_cmd = r;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
        cmds_taken++;
        want.left  = condition_wheel(l, last_left);
        want.right = condition_wheel(r, last_right);
        last_left  = want.left;
        last_right = want.right;
        if (typed) begin
            want.left  = el;
            want.right = er;
        end
        expected_drives.push_back(want);
    endtask

    // let the pipeline empty before touching registers
    task automatic settle_outputs(input int extra);
        @(negedge i_clk);
        cmd_bus.valid = 1'b0;
        while (expected_drives.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // drive receiver: changing stall patterns plus one long hold-off
    initial begin : drive_receiver
        t_rx_mode mode;
        int       mode_left;
        int       hold_left;
        bit       hold_done;
        bit       toggle;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        toggle    = 1'b0;
        drive_bus.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                drive_bus.ready = 1'b0;
                hold_left--;
            end else if (!hold_done && cmds_taken >= HOLD_AT) begin
                hold_done       = 1'b1;
                hold_left       = HOLD_CYCLES - 1;
                drive_bus.ready = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                toggle = !toggle;
                case (mode)
                    RX_OPEN:   drive_bus.ready = 1'b1;
                    RX_COIN:   drive_bus.ready = 1'($urandom_range(0, 1));
                    RX_MOSTLY: drive_bus.ready = ($urandom_range(0, 3) != 0);
                    default:   drive_bus.ready = toggle;
                endcase
            end
        end
    end

    // compare each drive transaction with the oldest expectation
    always @(posedge i_clk) begin : drive_check
        t_drive_pair want;
        if (i_rst_n && drive_bus.valid && drive_bus.ready) begin
            drives_seen++;
            if (expected_drives.size() == 0) begin
                $error("unexpected drive transaction: left %0d right %0d",
                       drive_bus.left_drive, drive_bus.right_drive);
                fails++;
            end else begin
                want = expected_drives.pop_front();
                if (drive_bus.left_drive !== want.left) begin
                    $error("left_drive mismatch: expected %0d, actual %0d",
                           want.left, drive_bus.left_drive);
                    fails++;
                end
                if (drive_bus.right_drive !== want.right) begin
                    $error("right_drive mismatch: expected %0d, actual %0d",
                           want.right, drive_bus.right_drive);
                    fails++;
                end
            end
        end
    end

    // stimulus
    initial begin : stimulus
        t_dir_row dir_tbl[];
        int       n_done;
        int       n_phase;
        int       phase;
        bit       full;

        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = '0;
        cfg_bus.data      = '0;
        cmd_bus.valid     = 1'b0;
        cmd_bus.left_cmd  = '0;
        cmd_bus.right_cmd = '0;
        i_rst_n           = 1'b0;

        dz_r       = DEAD_ZONE_RST;
        gain_r     = GAIN_RST;
        ofs_r      = OFFSET_RST;
        speed_r    = MAX_SPEED_RST;
        step_r     = MAX_STEP_RST;
        last_left  = '0;
        last_right = '0;

        dir_tbl = '{
            // reset settings: unity gain, no dead zone, no limits
            chk_row(16'sd0, 16'sd0, 16'sd0, 16'sd0),
            chk_row(16'sh7FFF, -16'sd32767, 16'sh7FFF, -16'sd32767),
            cmd_row(16'sh8000, 16'sh7FFF),
            cmd_row(16'sh8000, 16'sh8000),
            cmd_row(16'sd1, -16'sd1),
            // dead zone edge, gain 2.0, negative offset, clamp, slew
            cfg_row(REG_DEAD_ZONE, 16'd256),
            cfg_row(REG_GAIN, 16'd8192),
            cfg_row(REG_OFFSET, 16'hFE00),
            cfg_row(REG_MAX_SPEED, 16'd20000),
            cfg_row(REG_MAX_STEP, 16'd1000),
            cmd_row(16'sd255, -16'sd255),
            cmd_row(16'sd256, -16'sd256),
            cmd_row(16'sd300, -16'sd300),
            cmd_row(16'sh7FFF, 16'sh8000),
            cmd_row(16'sh7FFF, 16'sh8000),
            // negative scaled magnitude, overflow on negation, spare indexes
            cfg_row(REG_SPARE_FIRST, 16'hFFFF),
            cfg_row(REG_DEAD_ZONE, 16'd0),
            cfg_row(REG_GAIN, 16'd0),
            cfg_row(REG_OFFSET, 16'h8000),
            cfg_row(REG_MAX_SPEED, 16'h7FFF),
            cfg_row(REG_MAX_STEP, 16'h7FFF),
            cfg_row(REG_SPARE_LAST, 16'h0000),
            cmd_row(-16'sd1, 16'sd1),
            cmd_row(16'sd0, 16'sd0),
            cmd_row(-16'sd5, -16'sd5),
            cmd_row(-16'sd5, -16'sd5),
            cmd_row(-16'sd5, -16'sd5),
            // widest dead zone, zero clamp, frozen then free slew
            cfg_row(REG_DEAD_ZONE, 16'h7FFF),
            cfg_row(REG_GAIN, 16'hFFFF),
            cfg_row(REG_OFFSET, 16'h7FFF),
            cfg_row(REG_MAX_SPEED, 16'd0),
            cfg_row(REG_MAX_STEP, 16'd0),
            cmd_row(16'sh7FFF, 16'sh8000),
            cmd_row(16'sd100, -16'sd100),
            cfg_row(REG_MAX_STEP, 16'hFFFF),
            cmd_row(16'sh7FFF, -16'sd32767)
        };

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        foreach (dir_tbl[i]) begin
            if (dir_tbl[i].kind == ROW_CFG) begin
                settle_outputs(4);
                write_reg(dir_tbl[i].idx, dir_tbl[i].data);
            end else begin
                send_pair(dir_tbl[i].left, dir_tbl[i].right, dir_tbl[i].typed,
                          dir_tbl[i].want_left, dir_tbl[i].want_right);
            end
        end

        // random phases, each under its own register setting
        n_done = 0;
        phase  = 0;
        while (n_done < RAND_ITEMS) begin
            settle_outputs(4);
            if ($urandom_range(0, 2) == 0) begin
                write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                          CFG_DATA_W'($urandom));
            end
            full = (phase == 0);
            if (full || $urandom_range(0, 3) != 0) write_reg(REG_DEAD_ZONE, pick_limit());
            if (full || $urandom_range(0, 3) != 0) write_reg(REG_GAIN, pick_gain());
            if (full || $urandom_range(0, 3) != 0) write_reg(REG_OFFSET, pick_offset());
            if (full || $urandom_range(0, 3) != 0) write_reg(REG_MAX_SPEED, pick_limit());
            if (full || $urandom_range(0, 3) != 0) write_reg(REG_MAX_STEP, pick_limit());
            n_phase = full ? 250 : $urandom_range(40, 150);
            repeat (n_phase) begin
                send_pair(pick_cmd(), pick_cmd(), 1'b0, '0, '0);
                n_done++;
            end
            phase++;
        end

        settle_outputs(16);
        if (fails == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
